// ----- rtl/core/ssq_pkg.sv -----
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and codes for the searchable shift queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

	localparam int VAL_W       = 32;
	localparam int POS_W       = 4;
	localparam int MAX_RESULTS = 16;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t                 status;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item;
		logic                    last;
	} res_t;

endpackage

// ----- rtl/core/ssq_addr.sv -----
// ----------------------------------------------------------------------------
// ssq_addr
// Shared modular adder: maps a queue offset from the head to a slot address.
// ----------------------------------------------------------------------------
module ssq_addr #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic [AW-1:0] base,
	input  logic [AW-1:0] offset,
	output logic [AW-1:0] phys
);

	logic [AW:0] sum;

	always_comb begin
		sum = {1'b0, base} + {1'b0, offset};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		phys = sum[AW-1:0];
	end

endmodule

// ----- rtl/core/ssq_store.sv -----
// ----------------------------------------------------------------------------
// ssq_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssq_store import ssq_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [VAL_W-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic signed [VAL_W-1:0] rdata
);

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/searchable_shift_queue.sv -----
// ----------------------------------------------------------------------------
// searchable_shift_queue
// Queue of signed entries held as a ring in one memory, with add, remove,
// search and list operations run by a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: add, remove, a search for zero and an empty list go from idle
// straight to the output state, and the sequencer is idle again once the
// result is loaded. A search steps through the read and check states for each
// scanned entry; list steps through read, check and output for each result.
// One item at a time: cmd_ready is high only while the sequencer is idle.
// Reset clears head and fill count, so the queue reads as empty at once.
// ----------------------------------------------------------------------------
module searchable_shift_queue import ssq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CAPW = (CW > 5) ? CW : 5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_OUT
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic signed [VAL_W-1:0] key_q;
	logic [AW-1:0]           head_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic                    more_q;
	res_t                    pend_q;
	res_t                    res_q;
	logic                    res_valid_q;

	logic [AW-1:0]           offset;
	logic [AW-1:0]           phys;
	logic                    full;
	logic                    take;
	logic                    we;
	logic signed [VAL_W-1:0] rd_data;
	logic [CW-1:0]           idx_inc;
	logic                    at_end;
	logic                    cap;
	logic                    list_last;
	logic                    emit;
	res_t                    idle_res;
	state_t                  idle_next;

	assign cmd_ready = (state_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign idx_inc   = idx_q + CW'(1);
	assign at_end    = (idx_inc == count_q);
	assign cap       = (CAPW'(idx_inc) == CAPW'(MAX_RESULTS));
	assign list_last = at_end || cap;
	assign we        = take && (cmd.operation == OP_ADD) && (cmd.value != '0) && !full;
	assign emit      = (state_q == S_OUT) && (!res_valid_q || res_ready);

	always_comb begin
		if (state_q == S_RD) begin
			offset = idx_q[AW-1:0];
		end else if (cmd.operation == OP_REMOVE) begin
			offset = AW'(1);
		end else begin
			offset = count_q[AW-1:0];
		end
	end

	always_comb begin
		idle_res  = '{status: ST_OK, position: '0, item: '0, last: 1'b1};
		idle_next = S_OUT;
		case (cmd.operation)
			OP_ADD: begin
				if ((cmd.value != '0) && full) begin
					idle_res.status = ST_FULL;
				end
			end
			OP_SEARCH: begin
				if (cmd.value == '0) begin
					if (full) begin
						idle_res.status = ST_NOT_FOUND;
					end else begin
						idle_res.position = POS_W'(count_q);
					end
				end else if (count_q == '0) begin
					idle_res.status = ST_NOT_FOUND;
				end else begin
					idle_next = S_RD;
				end
			end
			OP_LIST: begin
				if (count_q == '0) begin
					idle_res.status = ST_EMPTY;
				end else begin
					idle_next = S_RD;
				end
			end
			default: begin
				idle_next = S_OUT;
			end
		endcase
	end

	ssq_addr #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_addr (
		.base   (head_q),
		.offset (offset),
		.phys   (phys)
	);

	ssq_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (phys),
		.wdata (cmd.value),
		.re    (state_q == S_RD),
		.raddr (phys),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_ADD;
			key_q       <= '0;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			more_q      <= 1'b0;
			pend_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= emit || (res_valid_q && !res_ready);
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.operation;
						key_q   <= cmd.value;
						idx_q   <= '0;
						more_q  <= 1'b0;
						pend_q  <= idle_res;
						state_q <= idle_next;
						if (we) begin
							count_q <= count_q + CW'(1);
						end else if ((cmd.operation == OP_REMOVE) && (count_q != '0)) begin
							head_q  <= phys;
							count_q <= count_q - CW'(1);
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					idx_q <= idx_inc;
					if (op_q == OP_LIST) begin
						pend_q  <= '{status: ST_OK, position: POS_W'(idx_q), item: rd_data,
							last: list_last};
						more_q  <= !list_last;
						state_q <= S_OUT;
					end else if (rd_data == key_q) begin
						pend_q  <= '{status: ST_OK, position: POS_W'(idx_q), item: '0,
							last: 1'b1};
						state_q <= S_OUT;
					end else if (at_end) begin
						pend_q  <= '{status: ST_NOT_FOUND, position: '0, item: '0, last: 1'b1};
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (emit) begin
						res_q   <= pend_q;
						state_q <= more_q ? S_RD : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- rtl/core/ssq_checker.sv -----
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks for the searchable shift queue, bound to the top level.
// ----------------------------------------------------------------------------
module ssq_checker import ssq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped or changed while stalled");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("new item taken while one is in progress");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_EMPTY |->
			res.last && res.item == '0 && res.position == '0)
		else $error("malformed empty list result");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> res.last)
		else $error("error result not marked last");

	a_list_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.item != '0 && res.status == ST_OK)
		else $error("non-final result carries no entry");

endmodule

bind searchable_shift_queue ssq_checker u_ssq_checker (.*);
